@@ src/dfla_pkg.sv @@
package dfla_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int FIRST_FREE        = 5;
  localparam int IDX_IN_W          = 8;

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WAIT
  } dfla_state_t;

  typedef struct packed {
    logic clr_step;
    logic do_release;
    logic do_full;
    logic do_alloc_rd;
    logic do_alloc_fin;
  } dfla_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic head_empty;
  } dfla_stat_t;

endpackage

@@ src/dfla_ram.sv @@
module dfla_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/dfla_ctrl.sv @@
module dfla_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 in_action,
  input  dfla_pkg::dfla_stat_t stat,
  output logic                 busy,
  output dfla_pkg::dfla_cmd_t  cmd
);

  dfla_pkg::dfla_state_t state_r;
  dfla_pkg::dfla_state_t state_nxt;
  logic                  accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dfla_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dfla_pkg::ST_CLEAR: begin
        if (stat.clr_last) begin
          state_nxt = dfla_pkg::ST_IDLE;
        end
      end
      dfla_pkg::ST_IDLE: begin
        if (start && (in_action == dfla_pkg::ACT_ALLOC) && !stat.head_empty) begin
          state_nxt = dfla_pkg::ST_WAIT;
        end
      end
      dfla_pkg::ST_WAIT: begin
        state_nxt = dfla_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = dfla_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy             = 1'b1;
    accept           = 1'b0;
    cmd              = '0;
    case (state_r)
      dfla_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      dfla_pkg::ST_IDLE: begin
        busy             = 1'b0;
        accept           = start;
        cmd.do_release   = accept && (in_action == dfla_pkg::ACT_RELEASE);
        cmd.do_full      = accept && (in_action == dfla_pkg::ACT_ALLOC) && stat.head_empty;
        cmd.do_alloc_rd  = accept && (in_action == dfla_pkg::ACT_ALLOC) && !stat.head_empty;
      end
      dfla_pkg::ST_WAIT: begin
        cmd.do_alloc_fin = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

@@ src/dfla_dpath.sv @@
module dfla_dpath #(
  parameter int TABLE_ENTRIES = dfla_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dfla_pkg::dfla_cmd_t           cmd,
  input  logic [dfla_pkg::IDX_IN_W-1:0] in_entry_index,
  output dfla_pkg::dfla_stat_t          stat,
  output logic                          out_valid,
  output logic                          out_status,
  output logic [dfla_pkg::IDX_IN_W-1:0] out_granted_entry
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int LINK_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [LINK_W-1:0] LIST_END  = LINK_W'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);

  logic [LINK_W-1:0]               head_r;
  logic [LINK_W-1:0]               head_nxt;
  logic [IDX_W-1:0]                clr_cnt_r;
  logic [IDX_W-1:0]                clr_cnt_nxt;
  logic                            out_valid_r;
  logic                            out_status_r;
  logic [dfla_pkg::IDX_IN_W-1:0]   out_granted_r;
  logic                            head_empty;
  logic                            rel_ok;
  logic [IDX_W-1:0]                rel_idx;
  logic                            ram_we;
  logic [IDX_W-1:0]                ram_waddr;
  logic [LINK_W-1:0]               ram_wdata;
  logic [LINK_W-1:0]               ram_rdata;

  assign head_empty = (head_r >= LIST_END);
  assign rel_ok     = (32'(in_entry_index) < 32'(TABLE_ENTRIES));
  assign rel_idx    = IDX_W'(in_entry_index);

  assign ram_we    = cmd.clr_step || (cmd.do_release && rel_ok);
  assign ram_waddr = cmd.clr_step ? clr_cnt_r : rel_idx;
  assign ram_wdata = cmd.clr_step ? (LINK_W'(clr_cnt_r) + LINK_W'(1))
                                  : (head_empty ? LIST_END : head_r);

  dfla_ram #(
    .WIDTH (LINK_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.do_alloc_rd),
    .raddr (head_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    head_nxt = head_r;
    if (cmd.do_release && rel_ok) begin
      head_nxt = LINK_W'(rel_idx);
    end else if (cmd.do_alloc_fin) begin
      head_nxt = (ram_rdata > LIST_END) ? LIST_END : ram_rdata;
    end
  end

  assign clr_cnt_nxt = cmd.clr_step ? (clr_cnt_r + IDX_W'(1)) : clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= LINK_W'(dfla_pkg::FIRST_FREE);
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= cmd.do_release || cmd.do_full || cmd.do_alloc_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_release || cmd.do_full || cmd.do_alloc_rd) begin
      out_status_r  <= cmd.do_full ? dfla_pkg::STATUS_FULL : dfla_pkg::STATUS_OK;
      out_granted_r <= cmd.do_alloc_rd ? dfla_pkg::IDX_IN_W'(head_r) : '0;
    end
  end

  assign stat.clr_last   = (clr_cnt_r == LAST_IDX);
  assign stat.head_empty = head_empty;

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_entry = out_granted_r;

endmodule

@@ src/descriptor_free_list_allocator.sv @@
// Release and allocate-on-full items give their result in the cycle after acceptance.
// A successful allocate reads the link memory at the head entry when accepted, then passes the
// wait state with busy high before its result is registered. One release is taken per cycle
// while idle; an allocate takes no new item until it is through, as its memory read is registered.
// After reset the link memory is initialized, one entry per cycle, for all TABLE_ENTRIES entries
// (256 by default) with busy high. Results are strobed for one cycle; the receiver cannot stall.
module descriptor_free_list_allocator #(
  parameter int TABLE_ENTRIES = dfla_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic [dfla_pkg::IDX_IN_W-1:0] in_entry_index,
  output logic                          out_valid,
  output logic                          out_status,
  output logic [dfla_pkg::IDX_IN_W-1:0] out_granted_entry
);

  dfla_pkg::dfla_cmd_t  cmd;
  dfla_pkg::dfla_stat_t stat;

  dfla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .stat      (stat),
    .busy      (busy),
    .cmd       (cmd)
  );

  dfla_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_entry_index    (in_entry_index),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_granted_entry (out_granted_entry)
  );

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr_step, cmd.do_release, cmd.do_full, cmd.do_alloc_rd, cmd.do_alloc_fin}))
    else $error("more than one datapath command in a cycle");

  a_alloc_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_alloc_rd |-> ##2 (out_valid && (out_status == dfla_pkg::STATUS_OK)))
    else $error("allocate item did not give its result two cycles later");

  a_short_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.do_release || cmd.do_full) |=> (out_valid && (out_granted_entry == '0)))
    else $error("release or full item did not give a zero grant one cycle later");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == dfla_pkg::STATUS_FULL)) |-> (out_granted_entry == '0))
    else $error("table full result carries a nonzero grant");

endmodule
